FILE: hw/rtl/grapheme_cluster_boundary_core_macros.svh
// Assertion macros shared by the grapheme cluster boundary RTL.
// No dependencies; included by the files that carry assertions.
`ifndef GRAPHEME_CLUSTER_BOUNDARY_CORE_MACROS_SVH
`define GRAPHEME_CLUSTER_BOUNDARY_CORE_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled during reset.
`define GCB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("grapheme cluster boundary assertion failed");

// Next-cycle implication, disabled during reset.
`define GCB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("grapheme cluster boundary assertion failed");

`else

`define GCB_ASSERT_NOW(label, clk, rst, ante, cons)

`define GCB_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: hw/rtl/gcb_pkg.sv
// Package with the break classes, widths and code point constants of the
// grapheme cluster boundary block. No dependencies.
package gcb_pkg;

   localparam int CP_W    = 21;
   localparam int TCLS_W  = 3;
   localparam int CONJ_W  = 2;
   localparam int COUNT_W = 24;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef enum logic [3:0] {
      CLS_OTHER   = 4'd0,
      CLS_CR      = 4'd1,
      CLS_LF      = 4'd2,
      CLS_CONTROL = 4'd3,
      CLS_EXTEND  = 4'd4,
      CLS_ZWJ     = 4'd5,
      CLS_RI      = 4'd6,
      CLS_PREPEND = 4'd7,
      CLS_SPACING = 4'd8,
      CLS_L       = 4'd9,
      CLS_V       = 4'd10,
      CLS_T       = 4'd11,
      CLS_LV      = 4'd12,
      CLS_LVT     = 4'd13,
      CLS_PICT    = 4'd14
   } break_class_type;

   typedef enum logic [2:0] {
      TC_OTHER   = 3'd0,
      TC_EXTEND  = 3'd1,
      TC_SPACING = 3'd2,
      TC_CONTROL = 3'd3,
      TC_PREPEND = 3'd4,
      TC_PICT    = 3'd5
   } table_class_type;

   typedef enum logic [1:0] {
      CONJ_NONE      = 2'd0,
      CONJ_LINKER    = 2'd1,
      CONJ_CONSONANT = 2'd2,
      CONJ_EXTEND    = 2'd3
   } conjunct_class_type;

   typedef enum logic [1:0] {
      CST_IDLE       = 2'd0,
      CST_CONSONANT  = 2'd1,
      CST_LINKED     = 2'd2
   } conjunct_state_type;

   localparam logic [CP_W-1:0] CP_CR       = 21'h0000D;
   localparam logic [CP_W-1:0] CP_LF       = 21'h0000A;
   localparam logic [CP_W-1:0] CP_ZWJ      = 21'h0200D;
   localparam logic [CP_W-1:0] CP_RI_LO    = 21'h1F1E6;
   localparam logic [CP_W-1:0] CP_RI_HI    = 21'h1F1FF;
   localparam logic [CP_W-1:0] CP_L1_LO    = 21'h01100;
   localparam logic [CP_W-1:0] CP_L1_HI    = 21'h0115F;
   localparam logic [CP_W-1:0] CP_L2_LO    = 21'h0A960;
   localparam logic [CP_W-1:0] CP_L2_HI    = 21'h0A97C;
   localparam logic [CP_W-1:0] CP_V1_LO    = 21'h01160;
   localparam logic [CP_W-1:0] CP_V1_HI    = 21'h011A7;
   localparam logic [CP_W-1:0] CP_V2_LO    = 21'h0D7B0;
   localparam logic [CP_W-1:0] CP_V2_HI    = 21'h0D7C6;
   localparam logic [CP_W-1:0] CP_T1_LO    = 21'h011A8;
   localparam logic [CP_W-1:0] CP_T1_HI    = 21'h011FF;
   localparam logic [CP_W-1:0] CP_T2_LO    = 21'h0D7CB;
   localparam logic [CP_W-1:0] CP_T2_HI    = 21'h0D7FB;
   localparam logic [CP_W-1:0] CP_SYL_LO   = 21'h0AC00;
   localparam logic [CP_W-1:0] CP_SYL_HI   = 21'h0D7A3;

   // Syllable offsets stay below 11172, so 14 bits hold them. The quotient
   // by 28 is (offset * SYL_RECIP) >> SYL_SHIFT, exact over that range.
   localparam int SYL_OFS_W = 14;
   localparam int SYL_SHIFT = 19;
   localparam int SYL_RECIP_W = 15;
   localparam logic [SYL_RECIP_W-1:0] SYL_RECIP = 15'd18725;
   localparam int SYL_PRODUCT_W = SYL_OFS_W + SYL_RECIP_W;
   localparam int SYL_QUOT_W = SYL_PRODUCT_W - SYL_SHIFT;
   localparam logic [4:0] SYL_T_COUNT = 5'd28;

endpackage

FILE: hw/rtl/gcb_classify.sv
// Break class decoder: fixed classes from the code point, the rest from the
// looked-up table class. Depends on gcb_pkg.
module gcb_classify (
   input  logic [gcb_pkg::CP_W-1:0]   code_point,
   input  logic [gcb_pkg::TCLS_W-1:0] table_class,
   output gcb_pkg::break_class_type   break_class
);

   logic [gcb_pkg::SYL_OFS_W-1:0]     syl_ofs;
   logic [gcb_pkg::SYL_PRODUCT_W-1:0] syl_product;
   logic [gcb_pkg::SYL_QUOT_W-1:0]    syl_quot;
   logic [gcb_pkg::SYL_OFS_W-1:0]     syl_base;
   logic                              syl_is_lv;
   logic                              in_l;
   logic                              in_v;
   logic                              in_t;
   logic                              in_syl;
   logic                              in_ri;

   assign syl_ofs     = gcb_pkg::SYL_OFS_W'(code_point - gcb_pkg::CP_SYL_LO);
   assign syl_product = gcb_pkg::SYL_PRODUCT_W'(syl_ofs) *
                        gcb_pkg::SYL_PRODUCT_W'(gcb_pkg::SYL_RECIP);
   assign syl_quot    = syl_product[gcb_pkg::SYL_PRODUCT_W-1:gcb_pkg::SYL_SHIFT];
   assign syl_base    = gcb_pkg::SYL_OFS_W'(gcb_pkg::SYL_OFS_W'(syl_quot) *
                        gcb_pkg::SYL_OFS_W'(gcb_pkg::SYL_T_COUNT));
   assign syl_is_lv   = (syl_base == syl_ofs);

   assign in_ri  = (code_point >= gcb_pkg::CP_RI_LO) && (code_point <= gcb_pkg::CP_RI_HI);
   assign in_l   = ((code_point >= gcb_pkg::CP_L1_LO) && (code_point <= gcb_pkg::CP_L1_HI)) ||
                   ((code_point >= gcb_pkg::CP_L2_LO) && (code_point <= gcb_pkg::CP_L2_HI));
   assign in_v   = ((code_point >= gcb_pkg::CP_V1_LO) && (code_point <= gcb_pkg::CP_V1_HI)) ||
                   ((code_point >= gcb_pkg::CP_V2_LO) && (code_point <= gcb_pkg::CP_V2_HI));
   assign in_t   = ((code_point >= gcb_pkg::CP_T1_LO) && (code_point <= gcb_pkg::CP_T1_HI)) ||
                   ((code_point >= gcb_pkg::CP_T2_LO) && (code_point <= gcb_pkg::CP_T2_HI));
   assign in_syl = (code_point >= gcb_pkg::CP_SYL_LO) && (code_point <= gcb_pkg::CP_SYL_HI);

   always_comb begin
      if (code_point == gcb_pkg::CP_CR) begin
         break_class = gcb_pkg::CLS_CR;
      end else if (code_point == gcb_pkg::CP_LF) begin
         break_class = gcb_pkg::CLS_LF;
      end else if (code_point == gcb_pkg::CP_ZWJ) begin
         break_class = gcb_pkg::CLS_ZWJ;
      end else if (in_ri) begin
         break_class = gcb_pkg::CLS_RI;
      end else if (in_l) begin
         break_class = gcb_pkg::CLS_L;
      end else if (in_v) begin
         break_class = gcb_pkg::CLS_V;
      end else if (in_t) begin
         break_class = gcb_pkg::CLS_T;
      end else if (in_syl) begin
         break_class = syl_is_lv ? gcb_pkg::CLS_LV : gcb_pkg::CLS_LVT;
      end else begin
         case (table_class)
            gcb_pkg::TC_EXTEND:  break_class = gcb_pkg::CLS_EXTEND;
            gcb_pkg::TC_SPACING: break_class = gcb_pkg::CLS_SPACING;
            gcb_pkg::TC_CONTROL: break_class = gcb_pkg::CLS_CONTROL;
            gcb_pkg::TC_PREPEND: break_class = gcb_pkg::CLS_PREPEND;
            gcb_pkg::TC_PICT:    break_class = gcb_pkg::CLS_PICT;
            default:             break_class = gcb_pkg::CLS_OTHER;
         endcase
      end
   end

endmodule

FILE: hw/rtl/grapheme_cluster_boundary_core.sv
// Extended grapheme cluster boundary detector, top level.
// Depends on gcb_pkg, gcb_classify and grapheme_cluster_boundary_core_macros.svh.
//
// The req channel takes one code point per transaction together with its
// looked-up table class, its Indic conjunct class and a first-of-text flag.
// The rsp channel returns one transaction per request: whether a grapheme
// cluster starts at that code point and the saturating cluster count of the
// current text. Both channels are valid/ready.
// A request is captured in an input register; when the result register can
// advance, the break rules are evaluated against the stored context and the
// result register is loaded. One transaction is taken in every cycle while
// the receiver does not stall, limited only by the break decision and context
// update, which are combinational between the input and result registers.
// When the receiver stalls, the result register holds its transaction and the
// input register can hold one more; req_ready is low while both are full.
// Reset empties both registers and returns the context to "other" with a
// zero count; a text should open with first_of_text set.
`include "grapheme_cluster_boundary_core_macros.svh"

module grapheme_cluster_boundary_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [gcb_pkg::CP_W-1:0]            req_code_point,
   input  logic [gcb_pkg::TCLS_W-1:0]          req_table_class,
   input  logic [gcb_pkg::CONJ_W-1:0]          req_conjunct_class,
   input  logic                                req_first_of_text,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_starts_cluster,
   output logic [gcb_pkg::COUNT_W-1:0]         rsp_cluster_count
);

   logic                               in_valid_ff;
   logic [gcb_pkg::CP_W-1:0]           in_code_point_ff;
   logic [gcb_pkg::TCLS_W-1:0]         in_table_class_ff;
   logic [gcb_pkg::CONJ_W-1:0]         in_conjunct_class_ff;
   logic                               in_first_ff;

   logic                               out_valid_ff;
   logic                               out_starts_ff;

   gcb_pkg::break_class_type           prev_class_ff;
   gcb_pkg::break_class_type           prev_class_in;
   logic                               pict_run_ff;
   logic                               pict_run_in;
   logic                               parity_ff;
   logic                               parity_in;
   gcb_pkg::conjunct_state_type        conj_state_ff;
   gcb_pkg::conjunct_state_type        conj_state_in;
   logic [gcb_pkg::COUNT_W-1:0]        count_ff;
   logic [gcb_pkg::COUNT_W-1:0]        count_in;

   gcb_pkg::break_class_type           cur_class;
   logic                               rule_break;
   logic                               brk;
   logic                               advance;
   logic                               fire;
   logic                               prev_ctl;
   logic                               cur_ctl;
   logic                               ip_consonant;

   gcb_classify u_classify (
      .code_point  (in_code_point_ff),
      .table_class (in_table_class_ff),
      .break_class (cur_class)
   );

   assign advance   = !out_valid_ff || rsp_ready;
   assign fire      = advance && in_valid_ff;
   assign req_ready = !in_valid_ff || advance;

   assign prev_ctl = (prev_class_ff == gcb_pkg::CLS_CONTROL) ||
                     (prev_class_ff == gcb_pkg::CLS_CR) || (prev_class_ff == gcb_pkg::CLS_LF);
   assign cur_ctl  = (cur_class == gcb_pkg::CLS_CONTROL) ||
                     (cur_class == gcb_pkg::CLS_CR) || (cur_class == gcb_pkg::CLS_LF);
   assign ip_consonant = (in_conjunct_class_ff == gcb_pkg::CONJ_CONSONANT);

   // Break rules in their standard order of precedence.
   always_comb begin
      if (prev_class_ff == gcb_pkg::CLS_CR && cur_class == gcb_pkg::CLS_LF) begin
         rule_break = 1'b0;
      end else if (prev_ctl || cur_ctl) begin
         rule_break = 1'b1;
      end else if (prev_class_ff == gcb_pkg::CLS_L &&
                   (cur_class == gcb_pkg::CLS_L || cur_class == gcb_pkg::CLS_V ||
                    cur_class == gcb_pkg::CLS_LV || cur_class == gcb_pkg::CLS_LVT)) begin
         rule_break = 1'b0;
      end else if ((prev_class_ff == gcb_pkg::CLS_LV || prev_class_ff == gcb_pkg::CLS_V) &&
                   (cur_class == gcb_pkg::CLS_V || cur_class == gcb_pkg::CLS_T)) begin
         rule_break = 1'b0;
      end else if ((prev_class_ff == gcb_pkg::CLS_LVT || prev_class_ff == gcb_pkg::CLS_T) &&
                   cur_class == gcb_pkg::CLS_T) begin
         rule_break = 1'b0;
      end else if (cur_class == gcb_pkg::CLS_EXTEND || cur_class == gcb_pkg::CLS_ZWJ ||
                   cur_class == gcb_pkg::CLS_SPACING) begin
         rule_break = 1'b0;
      end else if (prev_class_ff == gcb_pkg::CLS_PREPEND) begin
         rule_break = 1'b0;
      end else if (conj_state_ff == gcb_pkg::CST_LINKED && ip_consonant) begin
         rule_break = 1'b0;
      end else if (pict_run_ff && prev_class_ff == gcb_pkg::CLS_ZWJ &&
                   cur_class == gcb_pkg::CLS_PICT) begin
         rule_break = 1'b0;
      end else if (prev_class_ff == gcb_pkg::CLS_RI && cur_class == gcb_pkg::CLS_RI &&
                   parity_ff) begin
         rule_break = 1'b0;
      end else begin
         rule_break = 1'b1;
      end
   end

   assign brk = in_first_ff || rule_break;

   always_comb begin
      if (in_first_ff) begin
         count_in = gcb_pkg::COUNT_W'(1);
      end else if (rule_break && count_ff != gcb_pkg::COUNT_MAX) begin
         count_in = count_ff + gcb_pkg::COUNT_W'(1);
      end else begin
         count_in = count_ff;
      end

      if (cur_class == gcb_pkg::CLS_RI) begin
         parity_in = brk ? 1'b1 : !parity_ff;
      end else begin
         parity_in = 1'b0;
      end

      if (cur_class == gcb_pkg::CLS_PICT) begin
         pict_run_in = 1'b1;
      end else begin
         pict_run_in = !brk && pict_run_ff && prev_class_ff != gcb_pkg::CLS_ZWJ &&
                       (cur_class == gcb_pkg::CLS_EXTEND || cur_class == gcb_pkg::CLS_ZWJ);
      end

      if (brk) begin
         conj_state_in = ip_consonant ? gcb_pkg::CST_CONSONANT : gcb_pkg::CST_IDLE;
      end else if (ip_consonant) begin
         conj_state_in = gcb_pkg::CST_CONSONANT;
      end else if (conj_state_ff != gcb_pkg::CST_IDLE &&
                   in_conjunct_class_ff == gcb_pkg::CONJ_LINKER) begin
         conj_state_in = gcb_pkg::CST_LINKED;
      end else if (conj_state_ff != gcb_pkg::CST_IDLE &&
                   in_conjunct_class_ff == gcb_pkg::CONJ_EXTEND) begin
         conj_state_in = conj_state_ff;
      end else begin
         conj_state_in = gcb_pkg::CST_IDLE;
      end

      prev_class_in = cur_class;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         prev_class_ff <= gcb_pkg::CLS_OTHER;
         pict_run_ff   <= 1'b0;
         parity_ff     <= 1'b0;
         conj_state_ff <= gcb_pkg::CST_IDLE;
         count_ff      <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         if (fire) begin
            prev_class_ff <= prev_class_in;
            pict_run_ff   <= pict_run_in;
            parity_ff     <= parity_in;
            conj_state_ff <= conj_state_in;
            count_ff      <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_code_point_ff     <= req_code_point;
         in_table_class_ff    <= req_table_class;
         in_conjunct_class_ff <= req_conjunct_class;
         in_first_ff          <= req_first_of_text;
      end
      if (fire) begin
         out_starts_ff <= brk;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_starts_cluster = out_starts_ff;
   assign rsp_cluster_count  = count_ff;

   `GCB_ASSERT_NEXT(a_first_restarts, clock, reset, fire && in_first_ff,
      rsp_starts_cluster && rsp_cluster_count == gcb_pkg::COUNT_W'(1))
   `GCB_ASSERT_NEXT(a_no_break_holds, clock, reset, fire && !brk,
      rsp_cluster_count == $past(count_ff))
   `GCB_ASSERT_NEXT(a_count_monotonic, clock, reset, fire && !in_first_ff,
      rsp_cluster_count >= $past(count_ff))
   `GCB_ASSERT_NOW(a_parity_needs_ri, clock, reset, parity_ff,
      prev_class_ff == gcb_pkg::CLS_RI)
   `GCB_ASSERT_NOW(a_conj_state_legal, clock, reset, 1'b1,
      conj_state_ff == gcb_pkg::CST_IDLE || conj_state_ff == gcb_pkg::CST_CONSONANT ||
      conj_state_ff == gcb_pkg::CST_LINKED)

endmodule
